/* src/frame_delay_queue_bit_error_top_macros.svh */
// assertion macros for the frame delay queue
// no dependencies; included by the modules that carry assertions
`ifndef FRAME_DELAY_QUEUE_BIT_ERROR_TOP_MACROS_SVH
`define FRAME_DELAY_QUEUE_BIT_ERROR_TOP_MACROS_SVH

// same-cycle implication
`define FDQBE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FDQBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/fdqbe_pkg.sv */
// shared types, codes and constants of the frame delay queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fdqbe_pkg;

  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;
  localparam int FL_W   = 12;
  localparam int BER_W  = 49;
  localparam int Q48    = 48;
  localparam int NS_W   = 30;

  localparam logic [63:0] NS_PER_S    = 64'd1000000000;
  localparam logic [63:0] SEED_RST    = 64'h9E3779B97F4A7C15;
  localparam logic [31:0] BITRATE_RST = 32'd500000;
  localparam logic [11:0] MTU_RST     = 12'd2048;

  localparam logic [2:0] REG_BITRATE = 3'd0;
  localparam logic [2:0] REG_PROP    = 3'd1;
  localparam logic [2:0] REG_MTU     = 3'd2;
  localparam logic [2:0] REG_BER     = 3'd3;
  localparam logic [2:0] REG_SEED    = 3'd4;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_OK,
    ST_STORED,
    ST_MTU_DROP,
    ST_FULL_DROP,
    ST_OVERSIZE,
    ST_NOT_READY
  } status_t;

  typedef struct packed {
    logic [31:0] bitrate;
    logic [31:0] prop;
    logic [11:0] mtu;
    logic [48:0] ber;
    logic [63:0] seed;
    logic        seed_load;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic push;
    logic roll;
    logic cmp;
    logic mod_start;
    logic flip_rd;
    logic flip_wr;
    logic mul;
    logic div_start;
    logic transit;
    logic commit;
    logic rd_none;
    logic rd_byte;
    logic rd_fin;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_read;
    logic commit_go;
    logic ber_nz;
    logic flip;
    logic div_done;
    logic div_busy;
    logic rd_ok;
    logic out_free;
  } dp_stat_t;

  function automatic logic [63:0] xorshift64(input logic [63:0] v);
    logic [63:0] x;
    x = v;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    return x;
  endfunction

endpackage

`default_nettype wire

/* src/fdqbe_regs.sv */
// configuration register file behind the apb-style port
// depends on fdqbe_pkg
`timescale 1ns / 1ps
`default_nettype none

module fdqbe_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fdqbe_pkg::CFG_AW-1:0] paddr,
  input  wire logic [fdqbe_pkg::CFG_DW-1:0] pwdata,
  output logic      [fdqbe_pkg::CFG_DW-1:0] prdata,
  output logic                             pready,
  output fdqbe_pkg::cfg_t                  cfg
);
  import fdqbe_pkg::*;

  logic [31:0] bitrate_r;
  logic [31:0] prop_r;
  logic [11:0] mtu_r;
  logic [48:0] ber_r;
  logic [63:0] seed_r;
  logic        seed_load_r;
  logic [2:0]  idx;
  logic        wr;

  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitrate_r   <= BITRATE_RST;
      prop_r      <= 32'd0;
      mtu_r       <= MTU_RST;
      ber_r       <= 49'd0;
      seed_r      <= SEED_RST;
      seed_load_r <= 1'b0;
    end else begin
      seed_load_r <= 1'b0;
      if (wr) begin
        case (idx)
          REG_BITRATE: bitrate_r <= pwdata[31:0];
          REG_PROP:    prop_r    <= pwdata[31:0];
          REG_MTU:     mtu_r     <= pwdata[11:0];
          REG_BER:     ber_r     <= pwdata[48:0];
          REG_SEED: begin
            seed_r      <= pwdata;
            seed_load_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_BITRATE: prdata = 64'(bitrate_r);
      REG_PROP:    prdata = 64'(prop_r);
      REG_MTU:     prdata = 64'(mtu_r);
      REG_BER:     prdata = 64'(ber_r);
      REG_SEED:    prdata = seed_r;
      default:     prdata = 64'd0;
    endcase
  end

  assign cfg.bitrate   = bitrate_r;
  assign cfg.prop      = prop_r;
  assign cfg.mtu       = mtu_r;
  assign cfg.ber       = ber_r;
  assign cfg.seed      = seed_r;
  assign cfg.seed_load = seed_load_r;

endmodule

`default_nettype wire

/* src/fdqbe_div.sv */
// restoring divider, one quotient bit per cycle
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module fdqbe_div #(
  parameter int WD = 64,
  parameter int WV = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [WD-1:0] dividend,
  input  wire logic [WV-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [WD-1:0]      quotient,
  output logic [WV-1:0]      remainder
);

  localparam int CW = $clog2(WD + 1);

  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [WD-1:0] quo_r;
  logic [WV-1:0] rem_r;
  logic [WV-1:0] div_r;
  logic [WV:0]   shifted;
  logic [WV:0]   diff;
  logic          ge;
  logic [WV-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[WD-1]};
    diff    = shifted - {1'b0, div_r};
    ge      = shifted >= {1'b0, div_r};
    rem_nxt = ge ? diff[WV-1:0] : shifted[WV-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WD);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[WD-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

/* src/fdqbe_ctrl.sv */
// sequencer of the frame delay queue: one request at a time
// depends on fdqbe_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "frame_delay_queue_bit_error_top_macros.svh"

module fdqbe_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire fdqbe_pkg::dp_stat_t stat,
  output fdqbe_pkg::dp_cmd_t       cmd
);
  import fdqbe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_ROLL,
    S_CMP,
    S_MODS,
    S_MODW,
    S_FRD,
    S_MUL,
    S_DIVS,
    S_DIVW,
    S_COMMIT,
    S_RSLOT,
    S_RBYTE,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   stall_r;
  logic   accept;

  assign accept   = in_valid && !stall_r;
  assign in_stall = stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = stat.in_read ? S_RSLOT : S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        if (!stat.commit_go) state_nxt = S_DONE;
        else if (stat.ber_nz) state_nxt = S_ROLL;
        else state_nxt = S_MUL;
      end
      S_ROLL: begin
        cmd.roll  = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = stat.flip ? S_MODS : S_MUL;
      end
      S_MODS: begin
        cmd.mod_start = 1'b1;
        state_nxt     = S_MODW;
      end
      S_MODW: begin
        if (stat.div_done) begin
          cmd.flip_rd = 1'b1;
          state_nxt   = S_FRD;
        end
      end
      S_FRD: begin
        cmd.flip_wr = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.transit = 1'b1;
          state_nxt   = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_RSLOT: begin
        if (stat.rd_ok) begin
          cmd.rd_byte = 1'b1;
          state_nxt   = S_RBYTE;
        end else begin
          cmd.rd_none = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_RBYTE: begin
        cmd.rd_fin = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stall_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stall_r <= (state_nxt != S_IDLE);
    end
  end

  `FDQBE_ASSERT_NOW(a_div_start_free, clk, rst_n, cmd.div_start || cmd.mod_start, !stat.div_busy, "divider started while busy")
  `FDQBE_ASSERT_NEXT(a_div_start_wait, clk, rst_n, cmd.div_start || cmd.mod_start, state_r == S_DIVW || state_r == S_MODW, "no wait state after divider start")
  `FDQBE_ASSERT_NOW(a_div_done_wait, clk, rst_n, stat.div_done, state_r == S_DIVW || state_r == S_MODW, "divider finished outside a wait state")

endmodule

`default_nettype wire

/* src/fdqbe_dp.sv */
// datapath: frame ring memory, slot tables, generator, divider and result registers
// depends on fdqbe_pkg and fdqbe_div
`timescale 1ns / 1ps
`default_nettype none

module fdqbe_dp #(
  parameter int QUEUE_DEPTH     = 16,
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fdqbe_pkg::dp_cmd_t  cmd,
  output fdqbe_pkg::dp_stat_t      stat,
  input  wire fdqbe_pkg::cfg_t     cfg,
  input  wire logic                in_cmd,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                in_last_byte,
  input  wire logic [31:0]         in_frame_tag,
  input  wire logic [7:0]          in_frame_priority,
  input  wire logic [11:0]         in_read_limit,
  input  wire logic [63:0]         in_now_ns,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               out_status,
  output logic [7:0]               out_byte,
  output logic                     out_last,
  output logic [31:0]              out_tag,
  output logic [11:0]              out_frame_length,
  output logic                     out_corrupted
);
  import fdqbe_pkg::*;

  localparam int QW   = $clog2(QUEUE_DEPTH);
  localparam int WOW  = $clog2(MAX_FRAME_BYTES + 2);
  localparam int LW   = $clog2(MAX_FRAME_BYTES + 1);
  localparam int ROW  = $clog2(MAX_FRAME_BYTES);
  localparam int L8W  = LW + 3;
  localparam int PW   = BER_W + L8W;
  localparam int NUMW = L8W + NS_W;
  localparam int MEMD = QUEUE_DEPTH * MAX_FRAME_BYTES;
  localparam int AW   = $clog2(MEMD);

  // latched request
  logic        cmd_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [31:0] tag_r;
  logic [7:0]  prio_r;
  logic [11:0] limit_r;
  logic [63:0] now_r;

  // ring state
  logic [QW-1:0]  head_r;
  logic [QW-1:0]  tail_r;
  logic [WOW-1:0] wo_r;
  logic [ROW-1:0] ro_r;
  logic [63:0]    rng_r;
  logic [LW-1:0]  len_r;

  // commit arithmetic
  logic [PW-1:0]   prod_r;
  logic [NUMW-1:0] num_r;
  logic [63:0]     transit_r;
  logic [AW-1:0]   faddr_r;
  logic [2:0]      bsel_r;

  // memories
  logic [7:0]    frame_mem_r [MEMD];
  logic [7:0]    mem_rdata_r;
  logic [63:0]   slot_rt_r   [QUEUE_DEPTH];
  logic [LW-1:0] slot_len_r  [QUEUE_DEPTH];
  logic [31:0]   slot_tag_r  [QUEUE_DEPTH];
  logic [7:0]    slot_prio_r [QUEUE_DEPTH];
  logic [63:0]   rt_q_r;
  logic [LW-1:0] len_q_r;
  logic [31:0]   tag_q_r;

  // pending result and output stage
  status_t       res_status_r;
  logic [7:0]    res_byte_r;
  logic          res_last_r;
  logic [31:0]   res_tag_r;
  logic [FL_W-1:0] res_len_r;
  logic          res_corr_r;
  logic          out_valid_r;
  status_t       out_status_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic [31:0]   out_tag_r;
  logic [FL_W-1:0] out_len_r;
  logic          out_corr_r;

  logic [WOW-1:0] len_nxt;
  logic           oversize;
  logic           mtu_drop;
  logic           full;
  logic [QW-1:0]  tail_inc;
  logic [QW-1:0]  head_inc;
  logic [L8W-1:0] len8;
  logic           flip;
  logic [AW-1:0]  wr_base;
  logic [AW-1:0]  push_addr;
  logic [AW-1:0]  head_addr;
  logic [AW-1:0]  flip_addr;
  logic [L8W-1:0] bit_idx;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [31:0]    rate_eff;
  logic           div_start;
  logic [63:0]    div_dividend;
  logic [31:0]    div_divisor;
  logic           div_busy;
  logic           div_done;
  logic [63:0]    div_quo;
  logic [31:0]    div_rem;
  logic [64:0]    ready_sum;
  logic [63:0]    ready_time;
  logic [LW:0]    read_end;
  logic           release_head;
  logic           rd_ok;

  always_comb begin
    len_nxt  = (wo_r <= WOW'(MAX_FRAME_BYTES)) ? wo_r + WOW'(1) : wo_r;
    oversize = len_nxt > WOW'(MAX_FRAME_BYTES);
    mtu_drop = 32'(len_nxt) > 32'(cfg.mtu);
    tail_inc = (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + QW'(1);
    head_inc = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + QW'(1);
    full     = tail_inc == head_r;
    len8     = {len_r, 3'b000};
    flip     = (|prod_r[PW-1:Q48]) || (rng_r < {prod_r[Q48-1:0], {(64-Q48){1'b0}}});
    wr_base  = AW'(tail_r) * AW'(MAX_FRAME_BYTES);
    push_addr = wr_base + AW'(wo_r);
    head_addr = AW'(head_r) * AW'(MAX_FRAME_BYTES) + AW'(ro_r);
    bit_idx  = L8W'(div_rem);
    flip_addr = wr_base + AW'(bit_idx >> 3);
    rate_eff = (cfg.bitrate == 32'd0) ? 32'd1 : cfg.bitrate;
    rd_ok    = (head_r != tail_r) && (limit_r != 12'd0) && !(rt_q_r > now_r);
    ready_sum  = 65'(now_r) + 65'(transit_r);
    ready_time = ready_sum[64] ? {64{1'b1}} : ready_sum[63:0];
    read_end   = (32'(len_q_r) < 32'(limit_r)) ? (LW+1)'(len_q_r) : (LW+1)'(limit_r);
    release_head = 32'(ro_r) + 32'd1 >= 32'(read_end);
  end

  // frame byte memory: one write port, one registered read port
  assign mem_we    = (cmd.push && (wo_r < WOW'(MAX_FRAME_BYTES))) || cmd.flip_wr;
  assign mem_waddr = cmd.flip_wr ? faddr_r : push_addr;
  assign mem_wdata = cmd.flip_wr ? (mem_rdata_r ^ (8'd1 << bsel_r)) : byte_r;
  assign mem_re    = cmd.flip_rd || cmd.rd_byte;
  assign mem_raddr = cmd.flip_rd ? flip_addr : head_addr;

  always_ff @(posedge clk) begin
    if (mem_we) frame_mem_r[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= frame_mem_r[mem_raddr];
  end

  // slot tables, read continuously at the head slot
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot_rt_r[tail_r]   <= ready_time;
      slot_len_r[tail_r]  <= len_r;
      slot_tag_r[tail_r]  <= tag_r;
      slot_prio_r[tail_r] <= prio_r;
    end
    rt_q_r  <= slot_rt_r[head_r];
    len_q_r <= slot_len_r[head_r];
    tag_q_r <= slot_tag_r[head_r];
  end

  assign div_start    = cmd.div_start || cmd.mod_start;
  assign div_dividend = cmd.mod_start ? rng_r : 64'(num_r);
  assign div_divisor  = cmd.mod_start ? 32'(len8) : rate_eff;

  fdqbe_div #(
    .WD(64),
    .WV(32)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      wo_r        <= '0;
      ro_r        <= '0;
      rng_r       <= SEED_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg.seed_load) rng_r <= cfg.seed;
      else if (cmd.roll || (cmd.cmp && flip)) rng_r <= xorshift64(rng_r);
      if (cmd.push) wo_r <= last_r ? '0 : len_nxt;
      if (cmd.commit) tail_r <= tail_inc;
      if (cmd.rd_fin) begin
        if (release_head) begin
          ro_r   <= '0;
          head_r <= head_inc;
        end else begin
          ro_r <= ro_r + ROW'(1);
        end
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_cmd;
      byte_r  <= in_data_byte;
      last_r  <= in_last_byte;
      tag_r   <= in_frame_tag;
      prio_r  <= in_frame_priority;
      limit_r <= in_read_limit;
      now_r   <= in_now_ns;
    end
    if (cmd.roll) prod_r <= PW'(cfg.ber) * PW'(len8);
    if (cmd.mul) num_r <= NUMW'(len8) * NUMW'(NS_PER_S);
    if (cmd.flip_rd) begin
      faddr_r <= flip_addr;
      bsel_r  <= bit_idx[2:0];
    end
    if (cmd.transit) transit_r <= div_quo + 64'(cfg.prop);

    if (cmd.push) begin
      len_r      <= LW'(len_nxt);
      res_byte_r <= 8'd0;
      res_last_r <= 1'b0;
      res_tag_r  <= 32'd0;
      res_corr_r <= 1'b0;
      if (!last_r) begin
        res_status_r <= ST_STORED;
        res_len_r    <= '0;
      end else if (oversize) begin
        res_status_r <= ST_OVERSIZE;
        res_len_r    <= '0;
      end else if (mtu_drop) begin
        res_status_r <= ST_MTU_DROP;
        res_len_r    <= FL_W'(len_nxt);
      end else if (full) begin
        res_status_r <= ST_FULL_DROP;
        res_len_r    <= FL_W'(len_nxt);
      end else begin
        res_status_r <= ST_OK;
        res_len_r    <= FL_W'(len_nxt);
      end
    end
    if (cmd.flip_wr) res_corr_r <= 1'b1;
    if (cmd.commit) begin
      res_status_r <= ST_OK;
      res_len_r    <= FL_W'(len_r);
    end
    if (cmd.rd_none) begin
      res_status_r <= ST_NOT_READY;
      res_byte_r   <= 8'd0;
      res_last_r   <= 1'b0;
      res_tag_r    <= 32'd0;
      res_len_r    <= '0;
      res_corr_r   <= 1'b0;
    end
    if (cmd.rd_fin) begin
      res_status_r <= ST_OK;
      res_byte_r   <= mem_rdata_r;
      res_last_r   <= release_head;
      res_tag_r    <= tag_q_r;
      res_len_r    <= FL_W'(len_q_r);
      res_corr_r   <= 1'b0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_byte_r   <= res_byte_r;
      out_last_r   <= res_last_r;
      out_tag_r    <= res_tag_r;
      out_len_r    <= res_len_r;
      out_corr_r   <= res_corr_r;
    end
  end

  assign stat.in_read   = in_cmd == CMD_READ;
  assign stat.commit_go = (cmd_r == CMD_PUSH) && last_r && !oversize && !mtu_drop && !full;
  assign stat.ber_nz    = cfg.ber != '0;
  assign stat.flip      = flip;
  assign stat.div_done  = div_done;
  assign stat.div_busy  = div_busy;
  assign stat.rd_ok     = rd_ok;
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_byte         = out_byte_r;
  assign out_last         = out_last_r;
  assign out_tag          = out_tag_r;
  assign out_frame_length = out_len_r;
  assign out_corrupted    = out_corr_r;

endmodule

`default_nettype wire

/* src/frame_delay_queue_bit_error_top.sv */
// top level of the frame delay queue link emulator
// depends on fdqbe_pkg, fdqbe_regs, fdqbe_ctrl, fdqbe_dp (with fdqbe_div)
`timescale 1ns / 1ps
`default_nettype none

// Link emulator holding a ring of QUEUE_DEPTH frame slots (at most QUEUE_DEPTH-1 in use),
// each MAX_FRAME_BYTES long. Every request on the in_ channel yields exactly one
// result on the out_ channel. Requests are handled one at a time by a sequencer:
// a byte push steps through latch, memory write and result hand-off, a read that
// delivers a byte through latch, slot check, memory read and hand-off, and a read
// that finds nothing ready through latch, slot check and hand-off. A frame commit
// adds a multiply and a 64-step bit-serial divide for the serialisation time; when
// a bit error rate is set, a roll adds a generator step and a compare, and a flipped bit a
// 64-step modulo on the same divider plus a read-modify-write of the byte. A stalled
// output delays the hand-off. A new request may be taken while
// the previous result still waits on a stalled output. Configuration lives on an
// apb-style port, 64-bit registers at 8-byte spacing; writing rng_seed also
// reloads the generator. The frame store has no clearing pass; bytes are only
// read after being written.
module frame_delay_queue_bit_error_top #(
  parameter int QUEUE_DEPTH     = 16,
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_cmd,
  input  wire logic [7:0]                   in_data_byte,
  input  wire logic                         in_last_byte,
  input  wire logic [31:0]                  in_frame_tag,
  input  wire logic [7:0]                   in_frame_priority,
  input  wire logic [11:0]                  in_read_limit,
  input  wire logic [63:0]                  in_now_ns,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [2:0]                        out_status,
  output logic [7:0]                        out_byte,
  output logic                              out_last,
  output logic [31:0]                       out_tag,
  output logic [11:0]                       out_frame_length,
  output logic                              out_corrupted,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fdqbe_pkg::CFG_AW-1:0] paddr,
  input  wire logic [fdqbe_pkg::CFG_DW-1:0] pwdata,
  output logic      [fdqbe_pkg::CFG_DW-1:0] prdata,
  output logic                              pready
);
  import fdqbe_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // register file, configuration registers feeding the datapath
  fdqbe_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: owns the request handshake and steps the datapath
  fdqbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: ring memory, slot tables, generator, divider, output register
  fdqbe_dp #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg               (cfg),
    .in_cmd            (in_cmd),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .in_frame_tag      (in_frame_tag),
    .in_frame_priority (in_frame_priority),
    .in_read_limit     (in_read_limit),
    .in_now_ns         (in_now_ns),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_byte          (out_byte),
    .out_last          (out_last),
    .out_tag           (out_tag),
    .out_frame_length  (out_frame_length),
    .out_corrupted     (out_corrupted)
  );

endmodule

`default_nettype wire
